// ===== hdl/aabb_overlap_and_push_out_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the box overlap and push-out core
// Clocked properties on clk, disabled while arst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef AABB_OVERLAP_AND_PUSH_OUT_CORE_ASSERT_SVH
`define AABB_OVERLAP_AND_PUSH_OUT_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define AOP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define AOP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AOP_ASSERT_IMP(lbl, ante, cons, msg)
`define AOP_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/aop_pkg.sv =====
// ----------------------------------------------------------------------------
// aop_pkg
// Shared widths, register indexes and word types of the box push-out core.
// ----------------------------------------------------------------------------
`default_nettype none

package aop_pkg;

	// coordinate format: signed fixed point
	localparam int COORD_BITS  = 32;
	localparam int MARGIN_BITS = 24;
	localparam int NUDGE_BITS  = 8;

	// one extra bit for a difference of two coordinates, two for margin compares
	localparam int INTR_BITS = COORD_BITS + 1;
	localparam int GAP_BITS  = COORD_BITS + 2;

	// configuration port
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = MARGIN_BITS;
	localparam logic [CFG_INDEX_BITS-1:0] REG_MARGIN = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NUDGE  = 2'd1;

	localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = '0;
	// about 0.01 with 8 fraction bits
	localparam logic [NUDGE_BITS-1:0]  NUDGE_RESET  = 8'd3;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [INTR_BITS-1:0]  intr_t;
	typedef logic        [INTR_BITS-1:0]  mag_t;
	typedef logic signed [GAP_BITS-1:0]   gap_t;

	// input word: mobile box a, solid box b
	typedef struct packed {
		coord_t a_x_low;
		coord_t a_x_high;
		coord_t a_y_low;
		coord_t a_y_high;
		coord_t a_z_low;
		coord_t a_z_high;
		coord_t b_x_low;
		coord_t b_x_high;
		coord_t b_y_low;
		coord_t b_y_high;
		coord_t b_z_low;
		coord_t b_z_high;
	} box_t;

	// output word
	typedef struct packed {
		logic   overlap;
		coord_t push_x;
		coord_t push_y;
	} result_t;

	// per-stage load enables
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_en_t;

endpackage

`default_nettype wire

// ===== hdl/aop_detect.sv =====
// ----------------------------------------------------------------------------
// aop_detect
// Stages 1 and 2: widened overlap test on three axes and x/y intrusion.
// ----------------------------------------------------------------------------
`default_nettype none

module aop_detect (
	input  wire logic                            clk,
	input  wire aop_pkg::box_t                   box,
	input  wire logic [aop_pkg::MARGIN_BITS-1:0] margin,
	input  wire aop_pkg::pipe_en_t               en,
	output aop_pkg::intr_t                       ux_s2,
	output aop_pkg::intr_t                       uy_s2,
	output aop_pkg::mag_t                        mag_x_s2,
	output aop_pkg::mag_t                        mag_y_s2,
	output logic                                 overlap_s2
);

	// compare flags and both candidate intrusions of one axis
	typedef struct packed {
		logic           lt_low;
		logic           lt_high;
		logic           gt_high;
		aop_pkg::intr_t in_left;
		aop_pkg::intr_t in_right;
	} axis_s1_t;

	// widened intervals meet when neither gap exceeds twice the margin
	function automatic logic axis_meets(aop_pkg::coord_t al, aop_pkg::coord_t ah,
			aop_pkg::coord_t bl, aop_pkg::coord_t bh, aop_pkg::gap_t twice);
		aop_pkg::gap_t gap_lo;
		aop_pkg::gap_t gap_hi;
		gap_lo = aop_pkg::GAP_BITS'(bl) - aop_pkg::GAP_BITS'(ah);
		gap_hi = aop_pkg::GAP_BITS'(al) - aop_pkg::GAP_BITS'(bh);
		return (gap_lo <= twice) && (gap_hi <= twice);
	endfunction

	// mobile [ml,mr] against solid [sl,sr]
	function automatic axis_s1_t axis_flags(aop_pkg::coord_t ml, aop_pkg::coord_t mr,
			aop_pkg::coord_t sl, aop_pkg::coord_t sr);
		axis_s1_t a;
		a.lt_low   = ml < sl;
		a.lt_high  = mr < sr;
		a.gt_high  = mr > sr;
		a.in_left  = aop_pkg::INTR_BITS'(sl) - aop_pkg::INTR_BITS'(mr);
		a.in_right = aop_pkg::INTR_BITS'(sr) - aop_pkg::INTR_BITS'(ml);
		return a;
	endfunction

	function automatic aop_pkg::intr_t intrusion(axis_s1_t a);
		aop_pkg::intr_t u;
		u = '0;
		if (a.lt_low) begin
			if (a.lt_high)
				u = a.in_left;
		end else if (a.gt_high) begin
			u = a.in_right;
		end
		return u;
	endfunction

	function automatic aop_pkg::mag_t magnitude(aop_pkg::intr_t v);
		aop_pkg::intr_t n;
		n = -v;
		return v[aop_pkg::INTR_BITS-1] ? aop_pkg::mag_t'(n) : aop_pkg::mag_t'(v);
	endfunction

	aop_pkg::gap_t twice;
	logic [2:0]    meet_s1;
	axis_s1_t      ax_s1;
	axis_s1_t      ay_s1;
	aop_pkg::intr_t ux;
	aop_pkg::intr_t uy;

	assign twice = {{(aop_pkg::GAP_BITS - aop_pkg::MARGIN_BITS - 1){1'b0}}, margin, 1'b0};

	// stage 1: per-axis overlap and compare flags
	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			meet_s1[0] <= axis_meets(box.a_x_low, box.a_x_high, box.b_x_low, box.b_x_high, twice);
			meet_s1[1] <= axis_meets(box.a_y_low, box.a_y_high, box.b_y_low, box.b_y_high, twice);
			meet_s1[2] <= axis_meets(box.a_z_low, box.a_z_high, box.b_z_low, box.b_z_high, twice);
			ax_s1      <= axis_flags(box.a_x_low, box.a_x_high, box.b_x_low, box.b_x_high);
			ay_s1      <= axis_flags(box.a_y_low, box.a_y_high, box.b_y_low, box.b_y_high);
		end
	end

	// stage 2: pick intrusions and their magnitudes
	assign ux = intrusion(ax_s1);
	assign uy = intrusion(ay_s1);

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			overlap_s2 <= &meet_s1;
			ux_s2      <= ux;
			uy_s2      <= uy;
			mag_x_s2   <= magnitude(ux);
			mag_y_s2   <= magnitude(uy);
		end
	end

endmodule

`default_nettype wire

// ===== hdl/aop_resolve.sv =====
// ----------------------------------------------------------------------------
// aop_resolve
// Stages 3 and 4: choose the push axis, add the nudge and saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module aop_resolve (
	input  wire logic                           clk,
	input  wire aop_pkg::pipe_en_t              en,
	input  wire logic                           overlap_s2,
	input  wire aop_pkg::intr_t                 ux_s2,
	input  wire aop_pkg::intr_t                 uy_s2,
	input  wire aop_pkg::mag_t                  mag_x_s2,
	input  wire aop_pkg::mag_t                  mag_y_s2,
	input  wire logic [aop_pkg::NUDGE_BITS-1:0] nudge,
	output aop_pkg::result_t                    result_s4
);

	localparam int SUM_BITS = aop_pkg::INTR_BITS + 1;
	localparam int TOP      = aop_pkg::COORD_BITS - 1;

	logic                       pick_y;
	logic                       overlap_s3;
	logic                       pick_y_s3;
	aop_pkg::intr_t             sel_s3;
	logic signed [SUM_BITS-1:0] nudge_ext;
	logic signed [SUM_BITS-1:0] sum;
	aop_pkg::coord_t            push;
	logic                       in_range;

	// y wins when x has no intrusion or y is nonzero and no larger
	assign pick_y = (ux_s2 == '0) || ((uy_s2 != '0) && (mag_y_s2 <= mag_x_s2));

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			overlap_s3 <= overlap_s2;
			pick_y_s3  <= pick_y;
			sel_s3     <= pick_y ? uy_s2 : ux_s2;
		end
	end

	// add nudge, clamp to the coordinate range
	assign nudge_ext = {{(SUM_BITS - aop_pkg::NUDGE_BITS){1'b0}}, nudge};
	assign sum       = {sel_s3[aop_pkg::INTR_BITS-1], sel_s3} + nudge_ext;
	assign in_range  = (sum[SUM_BITS-1:TOP] == '0) || (sum[SUM_BITS-1:TOP] == '1);

	always_comb begin
		if (in_range)
			push = sum[TOP:0];
		else if (sum[SUM_BITS-1])
			push = {1'b1, {TOP{1'b0}}};
		else
			push = {1'b0, {TOP{1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			result_s4.overlap <= overlap_s3;
			result_s4.push_x  <= (overlap_s3 && !pick_y_s3) ? push : '0;
			result_s4.push_y  <= (overlap_s3 && pick_y_s3) ? push : '0;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/aabb_overlap_and_push_out_core.sv =====
// ----------------------------------------------------------------------------
// aabb_overlap_and_push_out_core
// Three-axis box overlap test with push-out of the mobile box along x or y.
// ----------------------------------------------------------------------------
// Usage:
//   box channel (box_valid, box_stall, box) takes one pair of boxes per word.
//   hit channel (hit_valid, hit_stall, hit) returns one result word per box
//   word, in order: overlap flag and push along x or y (the other is zero).
//   cfg channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes margin
//   and nudge; cfg_ready is always high. Write only while no word is in flight.
// Pipeline: an accepted box word passes four register stages (margin test,
//   intrusion select, axis choice, nudge add with saturation) to hit_valid.
// Throughput: one word per cycle while the hit word is not stalled; every stage then takes a new word each cycle.
// Stall: a stalled hit word holds; upstream stages keep filling empty slots
//   and box_stall rises only once all four stages hold a word.
// Reset: clears all stage valid bits, margin to 0 and nudge to 3.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aabb_overlap_and_push_out_core_assert.svh"

module aabb_overlap_and_push_out_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                box_valid,
	output logic                                     box_stall,
	input  wire aop_pkg::box_t                       box,
	output logic                                     hit_valid,
	input  wire logic                                hit_stall,
	output aop_pkg::result_t                         hit,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [aop_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [aop_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	logic [aop_pkg::MARGIN_BITS-1:0] margin_q;
	logic [aop_pkg::NUDGE_BITS-1:0]  nudge_q;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	aop_pkg::pipe_en_t en;
	aop_pkg::intr_t    ux_s2, uy_s2;
	aop_pkg::mag_t     mag_x_s2, mag_y_s2;
	logic              overlap_s2;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q <= aop_pkg::MARGIN_RESET;
			nudge_q  <= aop_pkg::NUDGE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				aop_pkg::REG_MARGIN: margin_q <= cfg_data[aop_pkg::MARGIN_BITS-1:0];
				aop_pkg::REG_NUDGE:  nudge_q  <= cfg_data[aop_pkg::NUDGE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// a stage loads when empty or when its word moves on
	assign rdy_s4 = !vld_s4 || !hit_stall;
	assign rdy_s3 = !vld_s3 || rdy_s4;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign en.en_s1 = rdy_s1;
	assign en.en_s2 = rdy_s2;
	assign en.en_s3 = rdy_s3;
	assign en.en_s4 = rdy_s4;

	assign box_stall = !rdy_s1;
	assign hit_valid = vld_s4;

	// advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= box_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
			if (rdy_s3) vld_s3 <= vld_s2;
			if (rdy_s4) vld_s4 <= vld_s3;
		end
	end

	aop_detect u_detect (
		.clk        (clk),
		.box        (box),
		.margin     (margin_q),
		.en         (en),
		.ux_s2      (ux_s2),
		.uy_s2      (uy_s2),
		.mag_x_s2   (mag_x_s2),
		.mag_y_s2   (mag_y_s2),
		.overlap_s2 (overlap_s2)
	);

	aop_resolve u_resolve (
		.clk        (clk),
		.en         (en),
		.overlap_s2 (overlap_s2),
		.ux_s2      (ux_s2),
		.uy_s2      (uy_s2),
		.mag_x_s2   (mag_x_s2),
		.mag_y_s2   (mag_y_s2),
		.nudge      (nudge_q),
		.result_s4  (hit)
	);

	// a miss never pushes
	`AOP_ASSERT_IMP(a_miss_no_push, hit_valid && !hit.overlap, hit.push_x == '0 && hit.push_y == '0, "push on a miss")
	// only one axis is pushed
	`AOP_ASSERT_IMP(a_one_axis, hit_valid, hit.push_x == '0 || hit.push_y == '0, "push on both axes")
	// input stalls only with the whole pipe full and blocked
	`AOP_ASSERT_IMP(a_stall_full, box_stall, vld_s1 && vld_s2 && vld_s3 && vld_s4 && hit_stall, "stall with free slot")
	// a word leaving stage 3 lands in the output stage
	`AOP_ASSERT_NXT(a_s3_to_s4, vld_s3 && rdy_s4, vld_s4, "word lost between stages 3 and 4")

endmodule

`default_nettype wire

// ===== verif/tb_aabb_overlap_and_push_out_core.sv =====
// ----------------------------------------------------------------------------
// tb_aabb_overlap_and_push_out_core
// Self-checking bench for the box overlap and push-out core. Box pairs go in
// on the box channel; a local model predicts the overlap flag and the x or y
// push for each accepted pair and checks every hit word in order. Runs a
// corner list, then random pairs under several margin and nudge settings,
// with random gaps and stalls, one long receiver hold-off and a mid-run drain.
// ----------------------------------------------------------------------------
module tb_aabb_overlap_and_push_out_core;

	localparam aop_pkg::coord_t MAXC = 32'sh7FFF_FFFF;
	localparam aop_pkg::coord_t MINC = 32'sh8000_0000;
	localparam logic signed [34:0] PUSH_HI = 35'sh0_7FFF_FFFF;
	localparam logic signed [34:0] PUSH_LO = 35'sh7_8000_0000;
	localparam logic [aop_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
	localparam logic [aop_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;
	localparam int PHASE_WORDS = 300;
	localparam int BURST_WORDS = 30;
	localparam int LONG_HOLD = 100;
	localparam int WATCHDOG_LIMIT = 2000;

	// Predicts push-out words and checks the ones the core returns
	class push_checker;
		aop_pkg::result_t pushes_due[$];
		logic [aop_pkg::MARGIN_BITS-1:0] margin;
		logic [aop_pkg::NUDGE_BITS-1:0] nudge;
		int mismatches;

		function new();
			margin = aop_pkg::MARGIN_RESET;
			nudge = aop_pkg::NUDGE_RESET;
			mismatches = 0;
		endfunction

		function void write_reg(logic [aop_pkg::CFG_INDEX_BITS-1:0] idx,
				logic [aop_pkg::CFG_DATA_BITS-1:0] data);
			case (idx)
				aop_pkg::REG_MARGIN: margin = data[aop_pkg::MARGIN_BITS-1:0];
				aop_pkg::REG_NUDGE: nudge = data[aop_pkg::NUDGE_BITS-1:0];
				default: ;
			endcase
		endfunction

		// widened intervals meet, a shared end point included
		function logic axis_meets(logic signed [33:0] lo_a, logic signed [33:0] hi_a,
				logic signed [33:0] lo_b, logic signed [33:0] hi_b);
			logic signed [33:0] reach;
			reach = $signed({9'b0, margin, 1'b0});
			return !((lo_b - hi_a) > reach) && !((lo_a - hi_b) > reach);
		endfunction

		function logic signed [33:0] intrusion(logic signed [33:0] ml, logic signed [33:0] mr,
				logic signed [33:0] sl, logic signed [33:0] sr);
			if (ml < sl) begin
				if (mr < sr)
					return sl - mr;
			end else if (mr > sr) begin
				return sr - ml;
			end
			return '0;
		endfunction

		// add the nudge and saturate to the coordinate range
		function aop_pkg::coord_t nudged_push(logic signed [33:0] depth);
			logic signed [34:0] sum;
			sum = depth + $signed({1'b0, nudge});
			if (sum > PUSH_HI)
				sum = PUSH_HI;
			else if (sum < PUSH_LO)
				sum = PUSH_LO;
			return sum[aop_pkg::COORD_BITS-1:0];
		endfunction

		function aop_pkg::result_t predict_push(aop_pkg::box_t w);
			logic signed [33:0] ix, iy;
			logic [33:0] mx, my;
			aop_pkg::result_t r;
			r = '0;
			r.overlap = axis_meets(w.a_x_low, w.a_x_high, w.b_x_low, w.b_x_high) &&
				axis_meets(w.a_y_low, w.a_y_high, w.b_y_low, w.b_y_high) &&
				axis_meets(w.a_z_low, w.a_z_high, w.b_z_low, w.b_z_high);
			if (r.overlap) begin
				ix = intrusion(w.a_x_low, w.a_x_high, w.b_x_low, w.b_x_high);
				iy = intrusion(w.a_y_low, w.a_y_high, w.b_y_low, w.b_y_high);
				mx = (ix < 0) ? -ix : ix;
				my = (iy < 0) ? -iy : iy;
				// y wins on a zero x depth or a shallower-or-equal nonzero y depth
				if (ix == 0 || (iy != 0 && my <= mx))
					r.push_y = nudged_push(iy);
				else
					r.push_x = nudged_push(ix);
			end
			return r;
		endfunction

		function void note_box(aop_pkg::box_t w);
			pushes_due.push_back(predict_push(w));
		endfunction

		task report(string what);
			mismatches++;
			$display("%0t push check: %s", $time, what);
		endtask

		task check_hit(aop_pkg::result_t got);
			aop_pkg::result_t want;
			if (pushes_due.size() == 0) begin
				report($sformatf("hit word with none due: overlap=%0b push_x=%0d push_y=%0d",
					got.overlap, got.push_x, got.push_y));
				return;
			end
			want = pushes_due.pop_front();
			if (got.overlap !== want.overlap)
				report($sformatf("overlap %0b, want %0b", got.overlap, want.overlap));
			if (got.push_x !== want.push_x)
				report($sformatf("push_x %0d, want %0d", got.push_x, want.push_x));
			if (got.push_y !== want.push_y)
				report($sformatf("push_y %0d, want %0d", got.push_y, want.push_y));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic box_valid = 1'b0;
	logic box_stall;
	aop_pkg::box_t box_word = '0;
	logic hit_valid;
	logic hit_stall = 1'b0;
	aop_pkg::result_t hit_word;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [aop_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [aop_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

	push_checker sb = new();
	bit burst_mode = 1'b0;
	bit hold_request = 1'b0;
	int idle_cycles = 0;

	aabb_overlap_and_push_out_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.box_valid(box_valid),
		.box_stall(box_stall),
		.box(box_word),
		.hit_valid(hit_valid),
		.hit_stall(hit_stall),
		.hit(hit_word),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly back to back, sometimes short gaps, rarely long ones
	function automatic int sender_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 2);
		if (r < 97)
			return $urandom_range(3, 10);
		return $urandom_range(15, 50);
	endfunction

	function automatic int stall_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		if (r < 90)
			return $urandom_range(3, 6);
		if (r < 98)
			return $urandom_range(7, 15);
		return $urandom_range(20, 40);
	endfunction

	// Random box pair: mostly nearby boxes, some corner values, some pure noise
	function automatic aop_pkg::box_t random_box(input logic [aop_pkg::MARGIN_BITS-1:0] m);
		aop_pkg::coord_t f [12];
		aop_pkg::coord_t base, t;
		int mode, s, k;
		mode = $urandom_range(0, 19);
		if (mode == 0) begin
			for (k = 0; k < 12; k++)
				f[k] = $urandom;
		end else if (mode == 1) begin
			for (k = 0; k < 12; k++) begin
				case ($urandom_range(0, 7))
					0: f[k] = MINC;
					1: f[k] = MINC + 1;
					2: f[k] = -1;
					3: f[k] = 0;
					4: f[k] = 1;
					5: f[k] = MAXC - 1;
					6: f[k] = MAXC;
					default: f[k] = $urandom;
				endcase
			end
		end else begin
			case ($urandom_range(0, 2))
				0: s = 16;
				1: s = 4096;
				default: s = 1 << 20;
			endcase
			base = ($urandom_range(0, 3) == 0) ? aop_pkg::coord_t'($urandom) :
				aop_pkg::coord_t'(0);
			for (k = 0; k < 3; k++) begin
				f[2*k] = base + $urandom_range(0, 2*s) - s;
				f[2*k+1] = f[2*k] + $urandom_range(0, 2*s);
				f[6+2*k] = base + $urandom_range(0, 2*s) - s;
				f[7+2*k] = f[6+2*k] + $urandom_range(0, 2*s);
				// flip an interval now and then
				if ($urandom_range(0, 15) == 0) begin
					t = f[2*k];
					f[2*k] = f[2*k+1];
					f[2*k+1] = t;
				end
			end
			// put one axis exactly at, or one step past, the margin reach
			if (mode <= 4) begin
				k = $urandom_range(0, 2);
				if ($urandom_range(0, 1))
					f[6+2*k] = f[2*k+1] + aop_pkg::coord_t'({m, 1'b0}) +
						$urandom_range(0, 1);
				else
					f[2*k] = f[7+2*k] + aop_pkg::coord_t'({m, 1'b0}) +
						$urandom_range(0, 1);
			end
		end
		return {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
	endfunction

	// Offer one word, hold it until taken, then maybe idle
	task automatic send_box(input aop_pkg::box_t w);
		int gap;
		box_valid <= 1'b1;
		box_word <= w;
		@(posedge clk);
		while (box_stall)
			@(posedge clk);
		sb.note_box(w);
		gap = burst_mode ? 0 : sender_gap();
		if (gap > 0) begin
			box_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop offering and wait for every due word to come back
	task automatic drain();
		box_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pushes_due.size() != 0);
	endtask

	// Write margin and nudge, and the unused indexes after them when asked
	task automatic configure(input logic [aop_pkg::CFG_DATA_BITS-1:0] m,
			input logic [aop_pkg::CFG_DATA_BITS-1:0] n, input bit poke_unused);
		logic [aop_pkg::CFG_INDEX_BITS-1:0] idx [4];
		logic [aop_pkg::CFG_DATA_BITS-1:0] val [4];
		int k;
		idx = '{aop_pkg::REG_MARGIN, aop_pkg::REG_NUDGE, REG_SPARE_A, REG_SPARE_B};
		val = '{m, n, aop_pkg::CFG_DATA_BITS'($urandom), ~m};
		for (k = 0; k < (poke_unused ? 4 : 2); k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			sb.write_reg(idx[k], val[k]);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input logic [aop_pkg::CFG_DATA_BITS-1:0] m,
			input logic [aop_pkg::CFG_DATA_BITS-1:0] n,
			input bit poke_unused, input bit hold_off, input bit pause_mid);
		int k;
		drain();
		configure(m, n, poke_unused);
		burst_mode = 1'b1;
		if (hold_off)
			hold_request = 1'b1;
		for (k = 0; k < PHASE_WORDS; k++) begin
			if (k == BURST_WORDS)
				burst_mode = 1'b0;
			if (pause_mid && k == PHASE_WORDS / 2)
				drain();
			send_box(random_box(sb.margin));
		end
	endtask

	// Hit side: check each taken word, then pick the stall for the next edge
	initial begin : hit_sink
		int hold_left;
		int run_left;
		bit stalling;
		hold_left = 0;
		run_left = 0;
		stalling = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && hit_valid === 1'b1 && !hit_stall)
				sb.check_hit(hit_word);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				stalling = 1'b1;
			end else begin
				if (run_left == 0) begin
					stalling = ($urandom_range(0, 2) == 0);
					run_left = stalling ? stall_len() : $urandom_range(1, 12);
				end
				run_left--;
				if (burst_mode)
					stalling = 1'b0;
			end
			hit_stall <= stalling;
		end
	end

	// Watchdog: give up after a long stretch with no handshake anywhere
	always @(posedge clk) begin
		if ((box_valid && !box_stall) || (hit_valid && !hit_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("aabb_overlap_and_push_out_core regression: fail");
			$finish;
		end
	end

	initial begin : stimulus
		aop_pkg::box_t corners[$];
		int k;

		// corner pairs under the reset margin and nudge
		corners.push_back(aop_pkg::box_t'{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
		corners.push_back(aop_pkg::box_t'{MAXC, MAXC, MAXC, MAXC, MAXC, MAXC,
			MAXC, MAXC, MAXC, MAXC, MAXC, MAXC});
		corners.push_back(aop_pkg::box_t'{MINC, MINC, MINC, MINC, MINC, MINC,
			MINC, MINC, MINC, MINC, MINC, MINC});
		// apart on one axis only
		corners.push_back(aop_pkg::box_t'{0, 10, 0, 10, 0, 10, 11, 20, 0, 10, 0, 10});
		corners.push_back(aop_pkg::box_t'{0, 10, 0, 10, 0, 10, 0, 10, 11, 20, 0, 10});
		corners.push_back(aop_pkg::box_t'{0, 10, 0, 10, 0, 10, 0, 10, 0, 10, -20, -1});
		corners.push_back(aop_pkg::box_t'{MAXC - 1, MAXC, 0, 10, 0, 10,
			MINC, MINC + 1, 0, 10, 0, 10});
		corners.push_back(aop_pkg::box_t'{0, 10, 0, 10, MAXC - 1, MAXC,
			0, 10, 0, 10, MINC, MINC + 1});
		// touching end points
		corners.push_back(aop_pkg::box_t'{0, 10, 0, 10, 0, 10, 10, 20, 0, 10, 0, 10});
		// sticking out left, then right, of the solid on x
		corners.push_back(aop_pkg::box_t'{0, 100, 10, 20, 0, 10, 50, 200, 0, 100, 0, 10});
		corners.push_back(aop_pkg::box_t'{150, 300, 10, 20, 0, 10, 50, 200, 0, 100, 0, 10});
		// y shallower, y tied with x, x shallower
		corners.push_back(aop_pkg::box_t'{0, 100, 0, 100, 0, 10, 50, 200, 90, 200, 0, 10});
		corners.push_back(aop_pkg::box_t'{0, 100, 150, 300, 0, 10, 50, 200, 50, 200, 0, 10});
		corners.push_back(aop_pkg::box_t'{0, 100, 0, 100, 0, 10, 90, 200, 50, 200, 0, 10});
		// mobile spans the solid: no depth on x
		corners.push_back(aop_pkg::box_t'{0, 300, 0, 10, 0, 10, 50, 200, 0, 10, 0, 10});
		// reversed bounds, meeting and not
		corners.push_back(aop_pkg::box_t'{100, 40, 0, 10, 0, 10, 0, 200, 0, 10, 0, 10});
		corners.push_back(aop_pkg::box_t'{100, 0, 0, 10, 0, 10, 50, 60, 0, 10, 0, 10});
		// pushes that saturate, low and high, on x and on y
		corners.push_back(aop_pkg::box_t'{MINC, MAXC - 1, 0, 0, 0, 0,
			MINC + 1, MAXC, 0, 0, 0, 0});
		corners.push_back(aop_pkg::box_t'{MINC, MAXC, 0, 0, 0, 0,
			MINC, MAXC - 1, 0, 0, 0, 0});
		corners.push_back(aop_pkg::box_t'{0, 0, MINC, MAXC, 0, 0,
			0, 0, MINC, MAXC - 1, 0, 0});
		corners.push_back(aop_pkg::box_t'{0, 0, MINC, MAXC - 1, 0, 0,
			0, 0, MINC + 1, MAXC, 0, 0});

		// hold reset, then release on an edge
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < corners.size(); k++)
			send_box(corners[k]);

		// margin, nudge, unused-index poke, long hold-off, mid-phase drain
		run_phase(24'd0, 24'd0, 1'b0, 1'b0, 1'b0);
		run_phase(24'hFF_FFFF, 24'hFF_FFFF, 1'b0, 1'b1, 1'b0);
		run_phase(aop_pkg::CFG_DATA_BITS'($urandom_range(1, 255)),
			aop_pkg::CFG_DATA_BITS'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
		run_phase(24'd256, 24'h5A_5A80, 1'b1, 1'b0, 1'b0);
		run_phase(aop_pkg::CFG_DATA_BITS'($urandom_range(0, 24'hFF_FFFF)),
			aop_pkg::CFG_DATA_BITS'($urandom_range(0, 24'hFF_FFFF)), 1'b0, 1'b0, 1'b0);

		drain();
		repeat (20) @(posedge clk);
		if (sb.pushes_due.size() != 0)
			sb.report($sformatf("%0d push words never came back", sb.pushes_due.size()));
		if (sb.mismatches == 0)
			$display("aabb_overlap_and_push_out_core regression: pass");
		else
			$display("aabb_overlap_and_push_out_core regression: fail");
		$finish;
	end

endmodule

// ===== aabb_overlap_and_push_out_core.f =====
+incdir+hdl
hdl/aop_pkg.sv
hdl/aop_detect.sv
hdl/aop_resolve.sv
hdl/aabb_overlap_and_push_out_core.sv
verif/tb_aabb_overlap_and_push_out_core.sv
